[src/btil_pkg.sv]
// ----------------------------------------------------------------------------
// btil_pkg
// Shared types and constants for the binary trie IPv4 lookup block.
// ----------------------------------------------------------------------------
package btil_pkg;

  localparam int StoreBytes = 65536;
  localparam int AddrW = $clog2(StoreBytes);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_WRITE = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_RECORD_MODE = 2'd1;
  localparam logic [1:0] CFG_IPV6 = 2'd2;
  localparam logic [1:0] CFG_LOADED = 2'd3;

  localparam logic [1:0] MODE_24 = 2'd0;
  localparam logic [1:0] MODE_28 = 2'd1;
  localparam logic [1:0] MODE_32 = 2'd2;

  localparam logic [6:0] V6_STEPS = 7'd96;

  typedef struct packed {
    logic        opcode;
    logic [15:0] byte_address;
    logic [7:0]  byte_value;
    logic [31:0] ip_address;
  } cmd_t;

endpackage

[src/btil_front.sv]
// ----------------------------------------------------------------------------
// btil_front
// Input stage and two-entry command queue feeding the walk engine.
// ----------------------------------------------------------------------------
module btil_front
  import btil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_cmd,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  cmd_t        slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[src/btil_back.sv]
// ----------------------------------------------------------------------------
// btil_back
// Trie walk engine: owns the byte store, reads one node byte per cycle.
// ----------------------------------------------------------------------------
module btil_back
  import btil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  input  logic [15:0] num_nodes,
  input  logic [1:0]  record_size_mode,
  input  logic        ipv6_tree,
  input  logic [16:0] loaded_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] data_offset
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NODE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [7:0]  mem [StoreBytes];
  logic [7:0]  rd_data;
  logic [AddrW-1:0] rd_addr;

  logic [2:0]  state;
  logic [31:0] ip;
  logic [7:0]  steps_done;
  logic        v6_phase;
  logic [6:0]  v6_left;
  logic [5:0]  v4_left;
  logic [15:0] current_node;
  logic [16:0] valid_sz;
  logic [18:0] tree_bytes;
  logic [32:0] base;
  logic [3:0]  bytes_left;
  logic [3:0]  nbytes;
  logic [63:0] acc;
  logic        side;
  logic        out_full;
  logic [1:0]  res_status;
  logic [15:0] res_offset;

  logic [31:0] rec;
  logic [32:0] off;
  logic [3:0]  nb_c;

  assign q_ready = (state == S_IDLE) && !out_full;
  assign out_valid = out_full;
  assign status = res_status;
  assign data_offset = res_offset;

  always_comb begin
    nb_c = 4'd6 + {2'b00, record_size_mode};
    case (record_size_mode)
      MODE_24: rec = side ? {8'd0, acc[23:0]} : {8'd0, acc[47:24]};
      MODE_28: rec = side ? {4'd0, acc[27:0]} : {4'd0, acc[55:28]};
      MODE_32: rec = side ? acc[31:0] : acc[63:32];
      default: rec = 32'd0;
    endcase
    off = {14'd0, tree_bytes} + {1'b0, rec} - {17'd0, num_nodes};
    base = {17'd0, current_node} * {29'd0, nbytes};
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && !out_full && q_cmd.opcode == OP_WRITE) begin
      mem[q_cmd.byte_address[AddrW-1:0]] <= q_cmd.byte_value;
    end
    rd_data <= mem[rd_addr];
  end

  // the whole node is read into acc; the chosen side is picked afterwards
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      steps_done <= 8'd0;
      current_node <= 16'd0;
    end else begin
      if (out_full && out_ready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && !out_full) begin
            if (q_cmd.opcode == OP_WRITE) begin
              res_status <= ST_WRITE;
              res_offset <= 16'd0;
              out_full <= 1'b1;
            end else begin
              ip <= q_cmd.ip_address;
              valid_sz <= loaded_bytes > 17'(StoreBytes) ? 17'(StoreBytes) : loaded_bytes;
              tree_bytes <= {3'd0, num_nodes} * {15'd0, nb_c};
              nbytes <= nb_c;
              current_node <= 16'd0;
              steps_done <= 8'd0;
              v6_phase <= ipv6_tree;
              v6_left <= V6_STEPS;
              v4_left <= 6'd32;
              if (loaded_bytes == 17'd0 || num_nodes == 16'd0 ||
                  record_size_mode > MODE_32) begin
                res_status <= ST_MISS;
                res_offset <= 16'd0;
                out_full <= 1'b1;
              end else begin
                state <= S_NODE;
              end
            end
          end
        end
        S_NODE: begin
          if (v6_phase && v6_left == 7'd0) begin
            v6_phase <= 1'b0;
          end else if (!v6_phase && v4_left == 6'd0) begin
            res_status <= ST_MISS;
            res_offset <= 16'd0;
            state <= S_DONE;
          end else begin
            side <= v6_phase ? 1'b0 : ip[31];
            if (base + {29'd0, nbytes} > {16'd0, valid_sz}) begin
              res_status <= ST_MISS;
              res_offset <= 16'd0;
              state <= S_DONE;
            end else begin
              if (v6_phase) v6_left <= v6_left - 7'd1;
              else begin
                v4_left <= v4_left - 6'd1;
                ip <= {ip[30:0], 1'b0};
              end
              steps_done <= steps_done + 8'd1;
              rd_addr <= base[AddrW-1:0];
              bytes_left <= nbytes;
              acc <= 64'd0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // wait for the registered store read, then shift bytes in
          rd_addr <= rd_addr + AddrW'(1);
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (bytes_left != 4'd0) begin
            // left records sit in the top bytes: keep the whole node in acc
            acc <= (acc << 8) | {56'd0, rd_data};
            bytes_left <= bytes_left - 4'd1;
            rd_addr <= rd_addr + AddrW'(1);
          end else begin
            if (rec == {16'd0, num_nodes}) begin
              res_status <= ST_MISS;
              res_offset <= 16'd0;
              state <= S_DONE;
            end else if (rec > {16'd0, num_nodes}) begin
              if (off >= {16'd0, valid_sz} || off == 33'd0 || off > 33'hffff) begin
                res_status <= ST_MISS;
                res_offset <= 16'd0;
              end else begin
                res_status <= ST_FOUND;
                res_offset <= off[15:0];
              end
              state <= S_DONE;
            end else begin
              current_node <= rec[15:0];
              state <= S_NODE;
            end
          end
        end
        S_DONE: begin
          if (!out_full) begin
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/binary_trie_ip_lookup.sv]
// ----------------------------------------------------------------------------
// binary_trie_ip_lookup
// Byte-loaded binary trie IPv4 prefix lookup engine.
// ----------------------------------------------------------------------------
// A byte write is queued and, once the walk engine is idle and the output is
// free, gives a registered result. A lookup walks one trie node per step, and
// each step reads its 6 to 8 node bytes one per cycle from the byte store; a
// lookup takes up to 32 steps, or 128 in IPv6 mode. A result waiting on
// out_ready holds the walk. Items are queued two deep ahead of the walk.
module binary_trie_ip_lookup
  import btil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] byte_address,
  input  logic [7:0]  byte_value,
  input  logic [31:0] ip_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] data_offset
);

  logic [15:0] num_nodes;
  logic [1:0]  record_size_mode;
  logic        ipv6_tree;
  logic [16:0] loaded_bytes;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes <= 16'd0;
      record_size_mode <= 2'd0;
      ipv6_tree <= 1'b0;
      loaded_bytes <= 17'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT:  num_nodes <= cfg_data[15:0];
        CFG_RECORD_MODE: record_size_mode <= cfg_data[1:0];
        CFG_IPV6:        ipv6_tree <= cfg_data[0];
        CFG_LOADED:      loaded_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_cmd = '{opcode: opcode, byte_address: byte_address,
                    byte_value: byte_value, ip_address: ip_address};

  btil_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  btil_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .num_nodes(num_nodes), .record_size_mode(record_size_mode),
    .ipv6_tree(ipv6_tree), .loaded_bytes(loaded_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_offset(data_offset)
  );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_trie_ip_lookup: loads small tries in every
// record mode through byte writes, runs IPv4 lookups with random gaps and
// back-pressure, and checks each item against a built-in trie predictor.
// ----------------------------------------------------------------------------
module testbench;
  import btil_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CycleLimit = 10000000;
  localparam int ItemTarget = 1300;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] offset;
  } lookup_res_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [15:0] byte_address;
  logic [7:0]  byte_value;
  logic [31:0] ip_address;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [15:0] data_offset;

  bit [7:0]    trie_mem [StoreBytes];
  int unsigned node_cnt;
  logic [1:0]  rec_mode;
  bit          v6_walk;
  int unsigned loaded_cnt;

  lookup_res_t expected_q[$];
  int          errors;
  int          items_sent;
  int          stall_cycles;
  int          hold_req;
  int          hold_ack;
  int          cycle_cnt;

  binary_trie_ip_lookup u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .byte_address(byte_address), .byte_value(byte_value),
    .ip_address(ip_address), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_offset(data_offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic lookup_res_t predict_lookup(logic [31:0] ip);
    lookup_res_t res;
    longint valid, nbytes, base, off, rec, node, nc;
    int i;
    bit side;
    res.status = ST_MISS;
    res.offset = '0;
    valid = (loaded_cnt > StoreBytes) ? longint'(StoreBytes) : longint'(loaded_cnt);
    nbytes = longint'(6 + rec_mode);
    nc = longint'(node_cnt);
    node = 0;
    if (valid == 0 || nc == 0 || rec_mode == MODE_UNUSED) return res;
    for (i = 0; i < 128; i++) begin
      if (i < 96 && !v6_walk) continue;
      side = (i < 96) ? 1'b0 : ip[127 - i];
      base = node * nbytes;
      if (base + nbytes > valid) return res;
      case (rec_mode)
        MODE_24: begin
          off = base + (side ? 64'd3 : 64'd0);
          rec = longint'({trie_mem[off], trie_mem[off + 1], trie_mem[off + 2]});
        end
        MODE_28: begin
          if (!side)
            rec = longint'({trie_mem[base], trie_mem[base + 1], trie_mem[base + 2],
                            trie_mem[base + 3][7:4]});
          else
            rec = longint'({trie_mem[base + 3][3:0], trie_mem[base + 4],
                            trie_mem[base + 5], trie_mem[base + 6]});
        end
        default: begin
          off = base + (side ? 64'd4 : 64'd0);
          rec = longint'({trie_mem[off], trie_mem[off + 1], trie_mem[off + 2],
                          trie_mem[off + 3]});
        end
      endcase
      if (rec == nc) return res;
      if (rec > nc) begin
        off = nc * nbytes + (rec - nc);
        if (off >= valid || off == 0 || off > 65535) return res;
        res.status = ST_FOUND;
        res.offset = off[15:0];
        return res;
      end
      node = rec;
    end
    return res;
  endfunction

  // Sender: valid stays up across back-to-back items; only a gap or a drain lowers it.
  task automatic send_item(logic op, logic [15:0] addr, logic [7:0] val,
                           logic [31:0] ip);
    lookup_res_t res;
    in_valid     <= 1'b1;
    opcode       <= op;
    byte_address <= addr;
    byte_value   <= val;
    ip_address   <= ip;
    do @(posedge clk); while (!in_ready);
    if (op == OP_WRITE) begin
      trie_mem[addr] = val;
      res.status = ST_WRITE;
      res.offset = '0;
    end else begin
      res = predict_lookup(ip);
    end
    expected_q.push_back(res);
    items_sent++;
  endtask

  task automatic sender_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_write(logic [15:0] addr, logic [7:0] val, bit gaps);
    send_item(OP_WRITE, addr, val, $urandom);
    if (gaps) sender_gap();
  endtask

  task automatic send_lookup(logic [31:0] ip, bit gaps);
    send_item(OP_LOOKUP, 16'($urandom), 8'($urandom), ip);
    if (gaps) sender_gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(int unsigned nc, logic [1:0] mode, bit v6,
                           int unsigned loaded);
    drain();
    node_cnt = nc;
    rec_mode = mode;
    v6_walk = v6;
    loaded_cnt = loaded;
    cfg_we <= 1'b1;
    cfg_index <= CFG_NODE_COUNT;
    cfg_data <= 17'(nc);
    @(posedge clk);
    cfg_index <= CFG_RECORD_MODE;
    cfg_data <= 17'(mode);
    @(posedge clk);
    cfg_index <= CFG_IPV6;
    cfg_data <= 17'(v6);
    @(posedge clk);
    cfg_index <= CFG_LOADED;
    cfg_data <= 17'(loaded);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_record(int nnodes);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, nnodes - 1);
    if (r < 7) return node_cnt;
    return node_cnt + $urandom_range(1, 400);
  endfunction

  // Writes every byte of nodes 0..nnodes-1; records only point at these nodes.
  task automatic build_trie(int nnodes);
    int n, k, nbytes;
    logic [31:0] lrec, rrec;
    logic [7:0] b [8];
    nbytes = 6 + rec_mode;
    for (n = 0; n < nnodes; n++) begin
      lrec = pick_record(nnodes);
      rrec = pick_record(nnodes);
      case (rec_mode)
        MODE_24: {b[0], b[1], b[2], b[3], b[4], b[5]} = {lrec[23:0], rrec[23:0]};
        MODE_28: {b[0], b[1], b[2], b[3], b[4], b[5], b[6]} =
                   {lrec[27:0], rrec[27:0]};
        default: {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} = {lrec, rrec};
      endcase
      for (k = 0; k < nbytes; k++) send_write(16'(n * nbytes + k), b[k], 1'b1);
    end
  endtask

  task automatic run_traffic(int nlookups, int nnoise);
    int total, k;
    total = nlookups + nnoise;
    for (k = 0; k < total; k++) begin
      if ($urandom_range(0, total - 1) < nlookups) send_lookup($urandom, 1'b1);
      else send_write(16'($urandom_range(65535, 256)), 8'($urandom), 1'b1);
    end
  endtask

  task automatic test_directed();
    configure(0, MODE_24, 1'b0, 0);
    send_write(16'hffff, 8'hff, 1'b0);
    send_write(16'h0000, 8'h00, 1'b0);
    send_lookup(32'h0000_0000, 1'b0);
    send_lookup(32'hffff_ffff, 1'b0);
    configure(4, MODE_24, 1'b0, 65536);
    build_trie(3);
    send_lookup(32'h0000_0000, 1'b0);
    send_lookup(32'hffff_ffff, 1'b0);
    send_lookup(32'h8000_0001, 1'b0);
  endtask

  task automatic test_modes();
    int m;
    for (m = 0; m < 3; m++) begin
      configure(6, m[1:0], 1'b0, 65536);
      build_trie(6);
      run_traffic(40, 8);
    end
    configure(5, MODE_UNUSED, 1'b0, 65536);
    run_traffic(10, 2);
  endtask

  task automatic test_ipv6();
    configure(8, MODE_32, 1'b1, 65536);
    build_trie(8);
    run_traffic(20, 4);
  endtask

  task automatic test_bounds();
    // empty valid region, node past valid size, large node count, oversized load
    configure(6, MODE_28, 1'b0, 0);
    build_trie(6);
    run_traffic(10, 0);
    configure(6, MODE_28, 1'b0, 20);
    run_traffic(20, 0);
    configure(65535, MODE_24, 1'b0, 65536);
    build_trie(6);
    run_traffic(20, 0);
    configure(6, MODE_24, 1'b0, 131071);
    build_trie(6);
    run_traffic(20, 0);
  endtask

  task automatic test_backpressure();
    int k;
    configure(6, MODE_24, 1'b0, 65536);
    build_trie(6);
    drain();
    hold_req++;
    for (k = 0; k < 30; k++) send_lookup($urandom, 1'b0);
    drain();
  endtask

  task automatic test_random();
    int nnodes, nc, r;
    logic [1:0] mode;
    bit v6;
    int unsigned loaded;
    while (items_sent < ItemTarget) begin
      nnodes = $urandom_range(1, 16);
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(nnodes, 65535)
                                        : nnodes + $urandom_range(0, 4);
      mode = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
      v6 = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 9);
      loaded = (r < 4) ? 65536 : (r < 7) ? $urandom_range(0, nnodes * 8 + 400)
                                         : $urandom_range(0, 131071);
      configure(nc, mode, v6, loaded);
      if (mode != MODE_UNUSED) build_trie(nnodes);
      run_traffic(v6 ? 15 : 50, 15);
    end
  endtask

  // Result side: random stalls, plus long hold-off on request.
  always @(posedge clk) begin
    lookup_res_t exp_res;
    int r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item status=%0d offset=%0d", $time, status,
                   data_offset);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, status);
            errors++;
          end
          if (data_offset !== exp_res.offset) begin
            $display("%0t: data_offset expected %0d actual %0d", $time,
                     exp_res.offset, data_offset);
            errors++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        stall_cycles <= 800;
        out_ready <= 1'b0;
      end else if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        out_ready <= (r < 75) || (r >= 97);
        if (r >= 95 && r < 97) stall_cycles <= $urandom_range(10, 40);
      end
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    stall_cycles = 0;
    hold_req = 0;
    hold_ack = 0;
    cycle_cnt = 0;
    node_cnt = 0;
    rec_mode = MODE_24;
    v6_walk = 1'b0;
    loaded_cnt = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_WRITE;
    byte_address = '0;
    byte_value = '0;
    ip_address = '0;
    out_ready = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_modes();
    test_ipv6();
    test_bounds();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
src/btil_pkg.sv
src/btil_front.sv
src/btil_back.sv
src/binary_trie_ip_lookup.sv
verif/testbench.sv
